// File: sv/windowed_overload_limiter_core_macros.svh
// Assertion macros for the windowed overload limiter core.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef WINDOWED_OVERLOAD_LIMITER_CORE_MACROS_SVH
`define WINDOWED_OVERLOAD_LIMITER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WOL_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("windowed_overload_limiter_core: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define WOL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("windowed_overload_limiter_core: next-cycle check failed");

`endif

// File: sv/wol_pkg.sv
// Shared types and constants for the windowed overload limiter.
// No dependencies; every module of the block imports this package.
`default_nettype none

package wol_pkg;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned PHASE_W = 2;
	localparam int unsigned OUT_W   = 56;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Recovery ramp phases.
	localparam logic [PHASE_W-1:0] PHASE_NONE = 2'd0;
	localparam logic [PHASE_W-1:0] PHASE_ONE  = 2'd1;
	localparam logic [PHASE_W-1:0] PHASE_TWO  = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_BASE  = 2'd0;
	localparam logic [1:0] REG_HARD  = 2'd1;
	localparam logic [1:0] REG_RAMP1 = 2'd2;
	localparam logic [1:0] REG_RAMP2 = 2'd3;

	// How a request's time relates to the current window.
	typedef enum logic [2:0] {
		GAP_SAME = 3'd0,
		GAP_ONE  = 3'd1,
		GAP_TWO  = 3'd2,
		GAP_FWD  = 3'd3,
		GAP_BACK = 3'd4
	} gap_class_t;

	typedef struct packed {
		gap_class_t        gap_class;
		logic [TIME_W-1:0] time_now;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	typedef struct packed {
		logic [COUNT_W-1:0] base_limit;
		logic [COUNT_W-1:0] hard_limit;
		logic [COUNT_W-1:0] ramp_one_limit;
		logic [COUNT_W-1:0] ramp_two_limit;
	} limits_t;

endpackage

`default_nettype wire

// File: sv/windowed_overload_limiter_core.sv
// Channel   | Dir | Handshake                 | Payload
// s_*       | in  | s_tvalid / s_tready       | s_tdata: time_now (32)
// m_*       | out | m_tvalid / m_tready       | m_tdata: accept, peak_count, peak_second
// cfg_*     | in  | cfg_valid / cfg_ready     | cfg_index (2), cfg_data (16)
//
// One request per clock is sustained while the result output is not stalled. A request
// is written into the queue and then popped into the back end's result register, which
// raises m_tvalid. Reset clears all window, ramp and peak state and loads the register
// defaults. A stalled result output lets up to QUEUE_DEPTH requests collect before
// s_tready drops; configuration is always ready.
//
// Top level of the windowed overload limiter. Depends on wol_pkg, wol_front,
// wol_queue, wol_back and windowed_overload_limiter_core_macros.svh.
`default_nettype none

module windowed_overload_limiter_core #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// Request stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] time_now
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [0] accept, [16:1] peak_count, [48:17] peak_second,
	                               // [55:49] zero
	// Register write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import wol_pkg::*;

	`include "windowed_overload_limiter_core_macros.svh"

	// Limit registers. The hard limit powers up at its maximum so that, until it
	// is written, only the soft limit and alternation shape the traffic.
	limits_t limits_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.base_limit     <= '0;
			limits_q.hard_limit     <= COUNT_MAX;
			limits_q.ramp_one_limit <= '0;
			limits_q.ramp_two_limit <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BASE:  limits_q.base_limit     <= cfg_data;
				REG_HARD:  limits_q.hard_limit     <= cfg_data;
				REG_RAMP1: limits_q.ramp_one_limit <= cfg_data;
				REG_RAMP2: limits_q.ramp_two_limit <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Front end: each request transaction is classified against the window second
	// as it enters, so the back end never needs the 32-bit subtraction.
	logic          in_take;
	entry_t        front_entry;
	entry_t        queue_head;
	queue_status_t queue_status;
	logic          back_pop;

	assign s_tready = !queue_status.full;
	assign in_take  = s_tvalid && s_tready;

	wol_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (in_take),
		.time_now (s_tdata),
		.entry    (front_entry)
	);

	// The queue decouples request intake from result delivery.
	wol_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_take),
		.push_entry (front_entry),
		.pop        (back_pop),
		.head       (queue_head),
		.status     (queue_status)
	);

	// Back end: applies the limit rules and holds the result until it is taken.
	logic        res_accept;
	logic [15:0] res_peak_count;
	logic [31:0] res_peak_second;

	wol_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.limits          (limits_q),
		.head_valid      (!queue_status.empty),
		.head            (queue_head),
		.pop             (back_pop),
		.res_valid       (m_tvalid),
		.res_ready       (m_tready),
		.res_accept      (res_accept),
		.res_peak_count  (res_peak_count),
		.res_peak_second (res_peak_second)
	);

	assign m_tdata = {7'd0, res_peak_second, res_peak_count, res_accept};

	// The back end only takes an entry that is really there.
	`WOL_ASSERT_SAME(a_pop_not_empty, back_pop, !queue_status.empty)
	// A request pushed into an empty queue is still visible next cycle.
	`WOL_ASSERT_NEXT(a_push_lands, in_take && queue_status.empty, !queue_status.empty)
	// A new result only appears after the back end took an entry.
	`WOL_ASSERT_SAME(a_result_has_source, $rose(m_tvalid), $past(back_pop))

endmodule

`default_nettype wire

// File: sv/wol_front.sv
// Front end: classifies each accepted request against the current window second.
// Depends on wol_pkg.
`default_nettype none

module wol_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      take,
	input  logic [31:0]               time_now,
	output wol_pkg::entry_t           entry
);
	import wol_pkg::*;

	logic [TIME_W-1:0] window_q;
	logic [TIME_W-1:0] gap;

	assign gap = time_now - window_q;

	// The window always follows the latest request time, since a request in
	// the same second carries the window's own time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (take) begin
			window_q <= time_now;
		end
	end

	always_comb begin
		entry.time_now = time_now;
		if (gap == '0) begin
			entry.gap_class = GAP_SAME;
		end else if (gap == TIME_W'(1)) begin
			entry.gap_class = GAP_ONE;
		end else if (gap == TIME_W'(2)) begin
			entry.gap_class = GAP_TWO;
		end else if (!gap[TIME_W-1]) begin
			entry.gap_class = GAP_FWD;
		end else begin
			entry.gap_class = GAP_BACK;
		end
	end

endmodule

`default_nettype wire

// File: sv/wol_queue.sv
// Short FIFO of classified requests between front end and back end.
// Depends on wol_pkg.
`default_nettype none

module wol_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  wol_pkg::entry_t        push_entry,
	input  logic                   pop,
	output wol_pkg::entry_t        head,
	output wol_pkg::queue_status_t status
);
	import wol_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	entry_t            mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		if (p == PTR_W'(DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + PTR_W'(1);
		end
		return n;
	endfunction

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/wol_back.sv
// Back end: window state, limit decisions, peak tracking and the result register.
// Depends on wol_pkg.
`default_nettype none

module wol_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  wol_pkg::limits_t      limits,
	input  logic                  head_valid,
	input  wol_pkg::entry_t       head,
	output logic                  pop,
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic                  res_accept,
	output logic [15:0]           res_peak_count,
	output logic [31:0]           res_peak_second
);
	import wol_pkg::*;

	logic [TIME_W-1:0]  window_second_q;
	logic [COUNT_W-1:0] window_count_q;
	logic [COUNT_W-1:0] soft_limit_q;
	logic [PHASE_W-1:0] ramp_phase_q;
	logic               blocked_q;
	logic               alternate_q;
	logic [COUNT_W-1:0] peak_value_q;
	logic [TIME_W-1:0]  peak_time_q;

	logic               valid_q;
	logic               accept_q;

	logic [COUNT_W-1:0] cnt_inc;
	logic [COUNT_W-1:0] count_d;
	logic [COUNT_W-1:0] soft_d;
	logic [PHASE_W-1:0] phase_d;
	logic               blocked_d;
	logic               alternate_d;
	logic [COUNT_W-1:0] peak_value_d;
	logic [TIME_W-1:0]  peak_time_d;
	logic               accept_d;

	assign pop = head_valid && (!valid_q || res_ready);

	assign cnt_inc = (window_count_q != COUNT_MAX) ? window_count_q + COUNT_W'(1)
		: window_count_q;

	always_comb begin
		count_d      = window_count_q;
		soft_d       = soft_limit_q;
		phase_d      = ramp_phase_q;
		blocked_d    = blocked_q;
		alternate_d  = alternate_q;
		peak_value_d = peak_value_q;
		peak_time_d  = peak_time_q;
		accept_d     = 1'b1;
		if (head.gap_class == GAP_SAME) begin
			count_d = cnt_inc;
			if (limits.base_limit == '0) begin
				accept_d = 1'b1;
			end else if (blocked_q) begin
				accept_d = 1'b0;
			end else if (cnt_inc >= soft_limit_q && cnt_inc < limits.hard_limit) begin
				alternate_d = !alternate_q;
				accept_d    = !alternate_q;
			end else if (cnt_inc >= limits.hard_limit) begin
				blocked_d = 1'b1;
				accept_d  = 1'b0;
			end
		end else begin
			if (window_count_q > peak_value_q) begin
				peak_value_d = window_count_q;
				peak_time_d  = window_second_q;
			end
			count_d   = COUNT_W'(1);
			blocked_d = 1'b0;
			case (head.gap_class)
				GAP_ONE: begin
					if (blocked_q) begin
						phase_d = PHASE_ONE;
						soft_d  = limits.ramp_one_limit;
					end else if (ramp_phase_q == PHASE_ONE) begin
						phase_d = PHASE_TWO;
						soft_d  = limits.ramp_two_limit;
					end else if (ramp_phase_q == PHASE_TWO) begin
						phase_d = PHASE_NONE;
						soft_d  = limits.base_limit;
					end
				end
				GAP_TWO: begin
					if (blocked_q) begin
						phase_d = PHASE_TWO;
						soft_d  = limits.ramp_two_limit;
					end else if (ramp_phase_q != PHASE_NONE) begin
						phase_d = PHASE_NONE;
						soft_d  = limits.base_limit;
					end
				end
				GAP_FWD: begin
					phase_d = PHASE_NONE;
					soft_d  = limits.base_limit;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_second_q <= '0;
			window_count_q  <= '0;
			soft_limit_q    <= '0;
			ramp_phase_q    <= PHASE_NONE;
			blocked_q       <= 1'b0;
			alternate_q     <= 1'b0;
			peak_value_q    <= '0;
			peak_time_q     <= '0;
			valid_q         <= 1'b0;
		end else begin
			if (pop) begin
				window_second_q <= head.time_now;
				window_count_q  <= count_d;
				soft_limit_q    <= soft_d;
				ramp_phase_q    <= phase_d;
				blocked_q       <= blocked_d;
				alternate_q     <= alternate_d;
				peak_value_q    <= peak_value_d;
				peak_time_q     <= peak_time_d;
				valid_q         <= 1'b1;
			end else if (res_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			accept_q <= accept_d;
		end
	end

	assign res_valid       = valid_q;
	assign res_accept      = accept_q;
	assign res_peak_count  = peak_value_q;
	assign res_peak_second = peak_time_q;

endmodule

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for windowed_overload_limiter_core: directed requests, then random ones.
// Each result is checked with a bench model of windows, ramp and peak, or a written-out verdict.
// Depends on wol_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb;
	import wol_pkg::*;

	// Result fields, listed from the top bit down, so that the packed layout matches m_tdata:
	// accept in bit 0, peak_count above it, then peak_second.
	typedef struct packed {
		logic [TIME_W-1:0]  peak_second;
		logic [COUNT_W-1:0] peak_count;
		logic               accept;
	} verdict_t;

	typedef struct packed {
		logic [TIME_W-1:0] stamp;
		verdict_t          want;
	} verdict_entry_t;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

	// One row of the opening plan: a request, or a register write. Where typed is set, the
	// result is written out here instead of coming from the model.
	typedef struct packed {
		row_kind_e          kind;
		logic [TIME_W-1:0]  stamp;
		logic [1:0]         idx;
		logic [COUNT_W-1:0] val;
		logic               typed;
		verdict_t           want;
	} opening_row_t;

	localparam int OPENING_LEN = 31;

	// Verdicts are written { peak_second, peak_count, accept }.
	localparam opening_row_t OPENING_ROWS [OPENING_LEN] = '{
		// Reset state: limiting is off, so everything is admitted; the peak is still empty.
		'{ROW_REQ, 32'h0000_0000, REG_BASE, 16'd0, 1'b1, '{32'd0, 16'd0, 1'b1}},
		'{ROW_REQ, 32'h0000_0000, REG_BASE, 16'd0, 1'b1, '{32'd0, 16'd0, 1'b1}},
		// A new second closes the window of two requests at second zero.
		'{ROW_REQ, 32'h0000_0001, REG_BASE, 16'd0, 1'b1, '{32'd0, 16'd2, 1'b1}},
		// Time going back, at the top of the range, and then wrapping forward to zero.
		'{ROW_REQ, 32'hFFFF_FFFF, REG_BASE, 16'd0, 1'b1, '{32'd0, 16'd2, 1'b1}},
		'{ROW_REQ, 32'h0000_0000, REG_BASE, 16'd0, 1'b1, '{32'd0, 16'd2, 1'b1}},
		'{ROW_CFG, 32'h0000_0000, REG_BASE,  16'd4, 1'b0, '0},
		'{ROW_CFG, 32'h0000_0000, REG_HARD,  16'd6, 1'b0, '0},
		'{ROW_CFG, 32'h0000_0000, REG_RAMP1, 16'd2, 1'b0, '0},
		'{ROW_CFG, 32'h0000_0000, REG_RAMP2, 16'd3, 1'b0, '0},
		// The soft limit is still zero from reset, so these alternate.
		'{ROW_REQ, 32'h0000_0000, REG_BASE, 16'd0, 1'b0, '0},
		'{ROW_REQ, 32'h0000_0000, REG_BASE, 16'd0, 1'b0, '0},
		'{ROW_REQ, 32'h0000_0000, REG_BASE, 16'd0, 1'b0, '0},
		'{ROW_REQ, 32'h0000_0000, REG_BASE, 16'd0, 1'b0, '0},
		// Sixth request of the second reaches the hard limit; the next one finds it blocked.
		'{ROW_REQ, 32'h0000_0000, REG_BASE, 16'd0, 1'b1, '{32'd0, 16'd2, 1'b0}},
		'{ROW_REQ, 32'h0000_0000, REG_BASE, 16'd0, 1'b1, '{32'd0, 16'd2, 1'b0}},
		// Next second after a blocked one: first ramp step. The count kept running while
		// blocked, so the peak now holds seven at second zero.
		'{ROW_REQ, 32'h0000_0001, REG_BASE, 16'd0, 1'b1, '{32'd0, 16'd7, 1'b1}},
		'{ROW_REQ, 32'h0000_0001, REG_BASE, 16'd0, 1'b0, '0},
		'{ROW_REQ, 32'h0000_0001, REG_BASE, 16'd0, 1'b0, '0},
		// Second ramp step, then back to the base limit.
		'{ROW_REQ, 32'h0000_0002, REG_BASE, 16'd0, 1'b0, '0},
		'{ROW_REQ, 32'h0000_0003, REG_BASE, 16'd0, 1'b0, '0},
		'{ROW_REQ, 32'h0000_0003, REG_BASE, 16'd0, 1'b0, '0},
		'{ROW_REQ, 32'h0000_0003, REG_BASE, 16'd0, 1'b0, '0},
		'{ROW_REQ, 32'h0000_0003, REG_BASE, 16'd0, 1'b0, '0},
		'{ROW_REQ, 32'h0000_0003, REG_BASE, 16'd0, 1'b0, '0},
		'{ROW_REQ, 32'h0000_0003, REG_BASE, 16'd0, 1'b0, '0},
		// Gap of two after blocking, then a gap of two out of the ramp.
		'{ROW_REQ, 32'h0000_0005, REG_BASE, 16'd0, 1'b0, '0},
		'{ROW_REQ, 32'h0000_0007, REG_BASE, 16'd0, 1'b0, '0},
		// A gap of exactly half the range reads as negative; three seconds on is a long gap.
		'{ROW_REQ, 32'h8000_0007, REG_BASE, 16'd0, 1'b0, '0},
		'{ROW_REQ, 32'h8000_000A, REG_BASE, 16'd0, 1'b0, '0},
		// A hard limit of zero blocks the second request of a window.
		'{ROW_CFG, 32'h0000_0000, REG_HARD,  16'd0, 1'b0, '0},
		'{ROW_REQ, 32'h8000_000A, REG_BASE, 16'd0, 1'b0, '0}
	};

	localparam int PHASES      = 9;
	localparam int PHASE_ITEMS = 120;
	// A closing burst of requests in one second with no idling on either side.
	localparam int FLOOD_ITEMS = 40;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	// Travels beside s_tdata so that the checker knows which requests carry a written-out result.
	logic     s_typed;
	verdict_t s_want;

	// Model of the limiter: registers, then window, ramp and peak state.
	logic [COUNT_W-1:0] lim_base, lim_hard, lim_ramp1, lim_ramp2;
	logic [TIME_W-1:0]  win_second;
	logic [COUNT_W-1:0] win_count;
	logic [COUNT_W-1:0] soft_now;
	logic [PHASE_W-1:0] ramp_step;
	logic               win_blocked;
	logic               toggle;
	logic [COUNT_W-1:0] peak_seen;
	logic [TIME_W-1:0]  peak_at;

	verdict_entry_t pending_verdicts [$];
	int             faults;

	// Pacing state of the two sides of the stream.
	bit          hold_quiet;
	int          burst_left;
	int          rx_span;
	int          rx_mode;
	int          rx_stall;
	logic [31:0] clock_now;

	windowed_overload_limiter_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	// Advances the model by one request and returns what the block must answer.
	function automatic verdict_t limiter_decide(input logic [TIME_W-1:0] stamp);
		logic [TIME_W-1:0] gap;
		verdict_t          v;
		gap = stamp - win_second;
		v.accept = 1'b1;
		if (gap == '0) begin
			if (win_count != COUNT_MAX)
				win_count = win_count + COUNT_W'(1);
			if (lim_base == '0) begin
				v.accept = 1'b1;
			end else if (win_blocked) begin
				v.accept = 1'b0;
			end else if (win_count >= soft_now && win_count < lim_hard) begin
				toggle = ~toggle;
				v.accept = toggle;
			end else if (win_count >= lim_hard) begin
				win_blocked = 1'b1;
				v.accept = 1'b0;
			end
		end else begin
			// The window that just ended may set a new peak.
			if (win_count > peak_seen) begin
				peak_seen = win_count;
				peak_at = win_second;
			end
			win_count = COUNT_W'(1);
			win_second = stamp;
			if (gap == 32'd1) begin
				if (win_blocked) begin
					ramp_step = PHASE_ONE;
					soft_now = lim_ramp1;
				end else if (ramp_step == PHASE_ONE) begin
					ramp_step = PHASE_TWO;
					soft_now = lim_ramp2;
				end else if (ramp_step == PHASE_TWO) begin
					ramp_step = PHASE_NONE;
					soft_now = lim_base;
				end
			end else if (gap == 32'd2) begin
				if (win_blocked) begin
					ramp_step = PHASE_TWO;
					soft_now = lim_ramp2;
				end else if (ramp_step != PHASE_NONE) begin
					ramp_step = PHASE_NONE;
					soft_now = lim_base;
				end
			end else if (!gap[31]) begin
				// Long forward gap; a negative gap leaves the ramp alone.
				ramp_step = PHASE_NONE;
				soft_now = lim_base;
			end
			win_blocked = 1'b0;
		end
		v.peak_count = peak_seen;
		v.peak_second = peak_at;
		return v;
	endfunction

	task automatic flag_fault(input string what);
		faults++;
		if (faults <= 10)
			$display("%s", what);
	endtask

	// Every accepted request gets its expected verdict queued; every accepted result is
	// checked against the oldest one.
	always @(posedge clk) begin : watch
		verdict_t       seen;
		verdict_entry_t head;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				head.stamp = s_tdata;
				head.want = limiter_decide(s_tdata);
				if (s_typed)
					head.want = s_want;
				pending_verdicts.push_back(head);
			end
			if (m_tvalid && m_tready) begin
				seen = m_tdata[48:0];
				if (pending_verdicts.size() == 0) begin
					flag_fault($sformatf("unexpected result: accept %0d peak %0d at %h",
						seen.accept, seen.peak_count, seen.peak_second));
				end else begin
					head = pending_verdicts.pop_front();
					if (seen.accept !== head.want.accept
							|| seen.peak_count !== head.want.peak_count
							|| seen.peak_second !== head.want.peak_second)
						flag_fault($sformatf({"mismatch for request at %h: expected accept %0d ",
							"peak %0d at %h, got accept %0d peak %0d at %h"}, head.stamp,
							head.want.accept, head.want.peak_count, head.want.peak_second,
							seen.accept, seen.peak_count, seen.peak_second));
				end
			end
		end
	end

	// The receiver switches between spans with no stalls, light stalls and heavy stalls.
	always @(negedge clk) begin
		if (rx_span == 0) begin
			rx_span <= $urandom_range(50, 300);
			rx_mode <= $urandom_range(0, 2);
		end else begin
			rx_span <= rx_span - 1;
		end
		if (hold_quiet || rx_mode == 0) begin
			m_tready <= 1'b1;
		end else if (rx_stall > 0) begin
			m_tready <= 1'b0;
			rx_stall <= rx_stall - 1;
		end else if ($urandom_range(0, 99) < (rx_mode == 1 ? 15 : 45)) begin
			m_tready <= 1'b0;
			rx_stall <= $urandom_range(0, 4);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Offers one request from a falling edge and returns at a falling edge once it has been
	// taken. Between bursts the valid is dropped for a random number of cycles.
	task automatic push_request(input logic [31:0] stamp, input logic typed, input verdict_t want);
		s_tvalid <= 1'b1;
		s_tdata <= stamp;
		s_typed <= typed;
		s_want <= want;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		if (!hold_quiet) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6))
					@(negedge clk);
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
					: $urandom_range(0, 12);
			end
		end
	endtask

	// Stops offering requests and waits, with a bound, until every expected result has
	// arrived, then lets the block's latency pass with some margin.
	task automatic settle_results();
		int spent;
		s_tvalid <= 1'b0;
		spent = 0;
		while (pending_verdicts.size() != 0 && spent < 5000) begin
			@(negedge clk);
			spent++;
		end
		repeat (4)
			@(negedge clk);
	endtask

	// Register writes happen only with the block idle; the model takes the value at the
	// transaction.
	task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
		settle_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_BASE:  lim_base = val;
			REG_HARD:  lim_hard = val;
			REG_RAMP1: lim_ramp1 = val;
			REG_RAMP2: lim_ramp2 = val;
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Small limits let windows reach them; now and then a full-range value toggles every bit.
	function automatic logic [15:0] pick_limit();
		if ($urandom_range(0, 7) == 0)
			return 16'($urandom_range(0, 65535));
		return 16'($urandom_range(0, 10));
	endfunction

	// The first phases pin the extremes; the rest draw their limits at random.
	task automatic configure_phase(input int k);
		case (k)
			0: begin
				write_register(REG_BASE, 16'd0);
				write_register(REG_HARD, 16'hFFFF);
				write_register(REG_RAMP1, 16'd0);
				write_register(REG_RAMP2, 16'd0);
			end
			1: begin
				write_register(REG_BASE, 16'hFFFF);
				write_register(REG_HARD, 16'hFFFF);
				write_register(REG_RAMP1, 16'hFFFF);
				write_register(REG_RAMP2, 16'd0);
			end
			2: begin
				write_register(REG_BASE, 16'd3);
				write_register(REG_HARD, 16'd0);
				write_register(REG_RAMP1, 16'd1);
				write_register(REG_RAMP2, 16'd2);
			end
			3: begin
				write_register(REG_BASE, 16'd1);
				write_register(REG_HARD, 16'd2);
				write_register(REG_RAMP1, 16'd0);
				write_register(REG_RAMP2, 16'hFFFF);
			end
			default: begin
				write_register(REG_BASE, ($urandom_range(0, 9) == 0) ? 16'd0 : pick_limit());
				write_register(REG_HARD, pick_limit() + 16'($urandom_range(0, 6)));
				write_register(REG_RAMP1, pick_limit());
				write_register(REG_RAMP2, pick_limit());
			end
		endcase
	endtask

	// Mostly runs of requests within one second followed by a step of one or two seconds,
	// which is what it takes to reach the limits and walk the ramp. The rest are long gaps,
	// steps back in time, jumps across the signed boundary and fresh random times.
	task automatic random_phase(input int quota);
		int sent;
		int run;
		int pick;
		sent = 0;
		while (sent < quota) begin
			run = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 7);
			repeat (run) begin
				push_request(clock_now, 1'b0, '0);
				sent++;
			end
			pick = $urandom_range(0, 99);
			if (pick < 45)
				clock_now = clock_now + 32'd1;
			else if (pick < 65)
				clock_now = clock_now + 32'd2;
			else if (pick < 75)
				clock_now = clock_now + 32'($urandom_range(3, 1000));
			else if (pick < 83)
				clock_now = clock_now - 32'($urandom_range(1, 3));
			else if (pick < 88)
				clock_now = clock_now + 32'h8000_0000 - 32'($urandom_range(0, 1));
			else
				clock_now = $urandom;
			// Now and then the sender holds off until the result stream has drained.
			if ($urandom_range(0, 39) == 0)
				settle_results();
		end
	endtask

	initial begin : stimulus
		int i;
		int k;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_typed = 1'b0;
		s_want = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_BASE;
		cfg_data = '0;
		faults = 0;
		hold_quiet = 1'b0;
		burst_left = 0;
		rx_span = 0;
		rx_mode = 0;
		rx_stall = 0;
		lim_base = '0;
		lim_hard = COUNT_MAX;
		lim_ramp1 = '0;
		lim_ramp2 = '0;
		win_second = '0;
		win_count = '0;
		soft_now = '0;
		ramp_step = PHASE_NONE;
		win_blocked = 1'b0;
		toggle = 1'b0;
		peak_seen = '0;
		peak_at = '0;

		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Opening plan: limits at reset, the alternating region, the hard limit and the ramp.
		for (i = 0; i < OPENING_LEN; i++) begin
			if (OPENING_ROWS[i].kind == ROW_CFG)
				write_register(OPENING_ROWS[i].idx, OPENING_ROWS[i].val);
			else
				push_request(OPENING_ROWS[i].stamp, OPENING_ROWS[i].typed, OPENING_ROWS[i].want);
		end

		clock_now = $urandom;
		for (k = 0; k < PHASES; k++) begin
			configure_phase(k);
			random_phase(PHASE_ITEMS);
		end

		// Send one second back to back with no idling on either side, then step to the next
		// second so that the burst's count lands in the peak.
		hold_quiet = 1'b1;
		write_register(REG_BASE, 16'd1);
		write_register(REG_HARD, COUNT_MAX);
		clock_now = clock_now + 32'd5;
		repeat (FLOOD_ITEMS)
			push_request(clock_now, 1'b0, '0);
		push_request(clock_now + 32'd1, 1'b0, '0);
		push_request(clock_now + 32'd1, 1'b0, '0);
		hold_quiet = 1'b0;

		settle_results();
		if (pending_verdicts.size() != 0)
			$display("%0d expected results never arrived", pending_verdicts.size());
		if (faults == 0 && pending_verdicts.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// A correct run ends well inside this bound; reaching it means the block hung.
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

// File: sim.f
+incdir+sv
sv/wol_pkg.sv
sv/wol_front.sv
sv/wol_queue.sv
sv/wol_back.sv
sv/windowed_overload_limiter_core.sv
sim/tb.sv
